/* src/ipv4dq_pkg.sv */
// Shared types and constants for the IPv4 dotted-decimal address parser.
// No dependencies; used by ipv4_dotted_quad_parser_core.
package ipv4dq_pkg;

    // Item kinds carried on the input tuser bit
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Character codes and limits
    localparam logic [7:0] DOT_CHAR    = 8'h2E;
    localparam logic [7:0] ZERO_CHAR   = 8'h30;
    localparam logic [7:0] NINE_CHAR   = 8'h39;
    localparam logic [8:0] OCTET_MAX   = 9'd255;
    localparam logic [8:0] OCTET_SAT   = 9'd256;
    localparam logic [2:0] DOTS_NEEDED = 3'd3;
    localparam logic [2:0] DOTS_SAT    = 3'd7;
    localparam logic [1:0] DIGITS_SAT  = 2'd3;

    // Payload widths
    localparam int CH_W     = 8;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 40;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_EMPTY        = 3'd1,
        ST_BAD_CHAR     = 3'd2,
        ST_DOT_COUNT    = 3'd3,
        ST_EMPTY_OCTET  = 3'd4,
        ST_LEADING_ZERO = 3'd5,
        ST_RANGE        = 3'd6
    } status_t;

    // First fault seen among the closed octets
    typedef enum logic [1:0] {
        OF_NONE         = 2'd0,
        OF_EMPTY        = 2'd1,
        OF_LEADING_ZERO = 2'd2,
        OF_RANGE        = 2'd3
    } octet_fault_t;

endpackage

/* src/ipv4_dotted_quad_parser_core.sv */
// Top level of the IPv4 dotted-decimal address parser: input beat register,
// per-character parse state and result register. Depends on ipv4dq_pkg.
//
//  channel   | dir | tdata                               | tuser
//  s_axis    | in  | [7:0] ch                            | [0] func (1 = end)
//  m_axis    | out | [31:0] address, [34:32] status, pad | none
//
// One character beat per cycle while no end beat waits; each beat is held in the input register
// first, and an end beat's result then goes to the output register.
// The only stall is an end beat that finds an untaken result in the output
// register; character beats keep flowing past a stalled result.
// Reset (asynchronous, rst_n low) clears the handshake and parse state.
module ipv4_dotted_quad_parser_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ipv4dq_pkg::CH_W-1:0]     s_axis_tdata,   // [7:0] ch
    input  logic                            s_axis_tuser,   // [0] func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ipv4dq_pkg::OUT_W-1:0]    m_axis_tdata    // [31:0] address, [34:32] status
);

    // Input beat register
    logic                           in_valid_reg;
    logic                           in_func_reg;
    logic [ipv4dq_pkg::CH_W-1:0]    in_ch_reg;

    // Parse state
    logic [8:0]                     octet_value_reg, octet_value_next;
    logic [1:0]                     digit_count_reg, digit_count_next;
    logic                           first_zero_reg, first_zero_next;
    logic [2:0]                     dot_count_reg, dot_count_next;
    logic [31:0]                    addr_shift_reg, addr_shift_next;
    logic                           seen_char_reg, seen_char_next;
    logic                           bad_char_reg, bad_char_next;
    ipv4dq_pkg::octet_fault_t       octet_fault_reg, octet_fault_next;

    // Result register
    logic                               out_valid_reg;
    logic [ipv4dq_pkg::ADDR_W-1:0]      out_addr_reg;
    ipv4dq_pkg::status_t                out_status_reg;

    logic                           proc_fire;
    logic                           s_accept;
    logic                           is_digit;
    logic [3:0]                     digit;
    logic [11:0]                    acc_value;
    ipv4dq_pkg::octet_fault_t       close_fault;
    ipv4dq_pkg::octet_fault_t       fault_merged;
    logic [31:0]                    addr_closed;
    ipv4dq_pkg::status_t            end_status;

    // Character beats never need the result slot; end beats wait for it
    assign proc_fire = in_valid_reg &&
                       (in_func_reg == ipv4dq_pkg::FUNC_CHAR || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Digit decode and accumulate
    assign is_digit  = (in_ch_reg >= ipv4dq_pkg::ZERO_CHAR) && (in_ch_reg <= ipv4dq_pkg::NINE_CHAR);
    assign digit     = 4'(in_ch_reg - ipv4dq_pkg::ZERO_CHAR);
    assign acc_value = ({3'd0, octet_value_reg} << 3) + ({3'd0, octet_value_reg} << 1)
                       + {8'd0, digit};

    // Fault of the octet being closed: empty, then leading zero, then range
    always_comb
    begin
        if (digit_count_reg == 2'd0)
            close_fault = ipv4dq_pkg::OF_EMPTY;
        else if (digit_count_reg > 2'd1 && first_zero_reg)
            close_fault = ipv4dq_pkg::OF_LEADING_ZERO;
        else if (octet_value_reg > ipv4dq_pkg::OCTET_MAX)
            close_fault = ipv4dq_pkg::OF_RANGE;
        else
            close_fault = ipv4dq_pkg::OF_NONE;
    end

    assign fault_merged = (octet_fault_reg == ipv4dq_pkg::OF_NONE) ? close_fault : octet_fault_reg;
    assign addr_closed  = {addr_shift_reg[23:0], octet_value_reg[7:0]};

    // Status of an end beat, in priority order
    always_comb
    begin
        priority if (!seen_char_reg)
            end_status = ipv4dq_pkg::ST_EMPTY;
        else if (bad_char_reg)
            end_status = ipv4dq_pkg::ST_BAD_CHAR;
        else if (dot_count_reg != ipv4dq_pkg::DOTS_NEEDED)
            end_status = ipv4dq_pkg::ST_DOT_COUNT;
        else if (fault_merged != ipv4dq_pkg::OF_NONE)
            end_status = ipv4dq_pkg::status_t'(3'd3 + {1'b0, fault_merged});
        else
            end_status = ipv4dq_pkg::ST_OK;
    end

    // Parse state update
    always_comb
    begin
        octet_value_next = octet_value_reg;
        digit_count_next = digit_count_reg;
        first_zero_next  = first_zero_reg;
        dot_count_next   = dot_count_reg;
        addr_shift_next  = addr_shift_reg;
        seen_char_next   = seen_char_reg;
        bad_char_next    = bad_char_reg;
        octet_fault_next = octet_fault_reg;
        if (proc_fire)
        begin
            if (in_func_reg == ipv4dq_pkg::FUNC_END)
            begin
                // End of address: everything back to reset
                octet_value_next = '0;
                digit_count_next = '0;
                first_zero_next  = 1'b0;
                dot_count_next   = '0;
                addr_shift_next  = '0;
                seen_char_next   = 1'b0;
                bad_char_next    = 1'b0;
                octet_fault_next = ipv4dq_pkg::OF_NONE;
            end
            else
            begin
                seen_char_next = 1'b1;
                if (in_ch_reg == ipv4dq_pkg::DOT_CHAR)
                begin
                    if (dot_count_reg < ipv4dq_pkg::DOTS_SAT)
                        dot_count_next = dot_count_reg + 3'd1;
                    octet_fault_next = fault_merged;
                    addr_shift_next  = addr_closed;
                    octet_value_next = '0;
                    digit_count_next = '0;
                    first_zero_next  = 1'b0;
                end
                else if (is_digit)
                begin
                    if (digit_count_reg == 2'd0)
                        first_zero_next = (digit == 4'd0);
                    if (digit_count_reg < ipv4dq_pkg::DIGITS_SAT)
                        digit_count_next = digit_count_reg + 2'd1;
                    if (acc_value > {3'd0, ipv4dq_pkg::OCTET_MAX})
                        octet_value_next = ipv4dq_pkg::OCTET_SAT;
                    else
                        octet_value_next = acc_value[8:0];
                end
                else
                begin
                    bad_char_next = 1'b1;
                end
            end
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            octet_value_reg <= '0;
            digit_count_reg <= '0;
            first_zero_reg  <= 1'b0;
            dot_count_reg   <= '0;
            addr_shift_reg  <= '0;
            seen_char_reg   <= 1'b0;
            bad_char_reg    <= 1'b0;
            octet_fault_reg <= ipv4dq_pkg::OF_NONE;
        end
        else
        begin
            octet_value_reg <= octet_value_next;
            digit_count_reg <= digit_count_next;
            first_zero_reg  <= first_zero_next;
            dot_count_reg   <= dot_count_next;
            addr_shift_reg  <= addr_shift_next;
            seen_char_reg   <= seen_char_next;
            bad_char_reg    <= bad_char_next;
            octet_fault_reg <= octet_fault_next;

            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (proc_fire)
                in_valid_reg <= 1'b0;

            if (proc_fire && in_func_reg == ipv4dq_pkg::FUNC_END)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg <= s_axis_tuser;
            in_ch_reg   <= s_axis_tdata;
        end
        if (proc_fire && in_func_reg == ipv4dq_pkg::FUNC_END)
        begin
            out_status_reg <= end_status;
            out_addr_reg   <= (end_status == ipv4dq_pkg::ST_OK) ? addr_closed : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_status_reg, out_addr_reg};

    // Checks
    a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ipv4dq_pkg::ST_OK |-> out_addr_reg == '0)
        else $error("address not zero on an error result");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_func_reg == ipv4dq_pkg::FUNC_END
        |=> !seen_char_reg && dot_count_reg == '0 && digit_count_reg == '0)
        else $error("parse state not cleared after end beat");

    a_digits_seen: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg != '0 |-> seen_char_reg)
        else $error("digits counted with no character seen");

    a_octet_bound: assert property (@(posedge clk) disable iff (!rst_n)
        octet_value_reg <= ipv4dq_pkg::OCTET_SAT)
        else $error("octet value above saturation");

    a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_status_reg))
        else $error("stalled result lost or overwritten");

endmodule

/* bench/testbench.sv */
// Self-checking bench for ipv4_dotted_quad_parser_core: streams address text
// and end beats, predicts each parsed address and status, checks every result.
// Depends on ipv4dq_pkg and the core; needs nothing else.
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_MAX     = 10;

    typedef logic [7:0] text_t[$];

    typedef struct {
        logic [ipv4dq_pkg::ADDR_W-1:0] addr;
        ipv4dq_pkg::status_t           status;
    } parse_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ipv4dq_pkg::CH_W-1:0]      s_axis_tdata = '0;
    logic                             s_axis_tuser = ipv4dq_pkg::FUNC_CHAR;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [ipv4dq_pkg::OUT_W-1:0]     m_axis_tdata;

    // Bench controls
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  rx_hold = 0;
    bit  src_gaps_on = 1'b1;
    bit  sink_stalls_on = 1'b1;

    // Predicted parse state
    logic [8:0]                       oct_val = '0;
    logic [1:0]                       n_digits = '0;
    logic                             lead_zero = 1'b0;
    logic [2:0]                       n_dots = '0;
    logic [ipv4dq_pkg::ADDR_W-1:0]    addr_acc = '0;
    logic                             any_char = 1'b0;
    logic                             bad_char = 1'b0;
    ipv4dq_pkg::octet_fault_t         first_fault = ipv4dq_pkg::OF_NONE;

    // Parsed addresses still to come out of the core
    parse_result_t       parsed_q[$];

    ipv4_dotted_quad_parser_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Close the current octet: keep its first fault, shift its value in
    task automatic finish_octet();
        ipv4dq_pkg::octet_fault_t f;
        f = ipv4dq_pkg::OF_NONE;
        if (n_digits == 0)
            f = ipv4dq_pkg::OF_EMPTY;
        else if (n_digits > 1 && lead_zero)
            f = ipv4dq_pkg::OF_LEADING_ZERO;
        else if (oct_val > ipv4dq_pkg::OCTET_MAX)
            f = ipv4dq_pkg::OF_RANGE;
        if (first_fault == ipv4dq_pkg::OF_NONE)
            first_fault = f;
        addr_acc  = {addr_acc[23:0], oct_val[7:0]};
        oct_val   = '0;
        n_digits  = '0;
        lead_zero = 1'b0;
    endtask

    // Track one accepted input beat; an end beat yields one parsed address
    task automatic parse_beat(input logic func, input logic [7:0] ch);
        logic [12:0]   grown;
        parse_result_t res;
        if (func == ipv4dq_pkg::FUNC_CHAR)
        begin
            any_char = 1'b1;
            if (ch == ipv4dq_pkg::DOT_CHAR)
            begin
                if (n_dots != ipv4dq_pkg::DOTS_SAT)
                    n_dots = n_dots + 3'd1;
                finish_octet();
            end
            else if (ch >= ipv4dq_pkg::ZERO_CHAR && ch <= ipv4dq_pkg::NINE_CHAR)
            begin
                if (n_digits == 0)
                    lead_zero = (ch == ipv4dq_pkg::ZERO_CHAR);
                if (n_digits != ipv4dq_pkg::DIGITS_SAT)
                    n_digits = n_digits + 2'd1;
                grown = oct_val * 13'd10 + 13'(ch - ipv4dq_pkg::ZERO_CHAR);
                oct_val = (grown > 13'(ipv4dq_pkg::OCTET_MAX)) ? ipv4dq_pkg::OCTET_SAT
                                                                : grown[8:0];
            end
            else
                bad_char = 1'b1;
        end
        else
        begin
            finish_octet();
            res.addr = '0;
            if (!any_char)
                res.status = ipv4dq_pkg::ST_EMPTY;
            else if (bad_char)
                res.status = ipv4dq_pkg::ST_BAD_CHAR;
            else if (n_dots != ipv4dq_pkg::DOTS_NEEDED)
                res.status = ipv4dq_pkg::ST_DOT_COUNT;
            else
            begin
                case (first_fault)
                    ipv4dq_pkg::OF_EMPTY:        res.status = ipv4dq_pkg::ST_EMPTY_OCTET;
                    ipv4dq_pkg::OF_LEADING_ZERO: res.status = ipv4dq_pkg::ST_LEADING_ZERO;
                    ipv4dq_pkg::OF_RANGE:        res.status = ipv4dq_pkg::ST_RANGE;
                    default:
                    begin
                        res.status = ipv4dq_pkg::ST_OK;
                        res.addr   = addr_acc;
                    end
                endcase
            end
            parsed_q.push_back(res);
            // next address starts from scratch
            n_dots      = '0;
            addr_acc    = '0;
            any_char    = 1'b0;
            bad_char    = 1'b0;
            first_fault = ipv4dq_pkg::OF_NONE;
        end
    endtask

    // Offer one beat; called and returns at a falling edge, valid left high
    task automatic send_beat(input logic func, input logic [7:0] ch);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 8'($urandom);
            s_axis_tuser  = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = ch;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_beat(func, ch);
        @(negedge clk);
    endtask

    // One address: its characters, then an end beat with a junk byte
    task automatic send_text(input text_t txt);
        foreach (txt[i])
            send_beat(ipv4dq_pkg::FUNC_CHAR, txt[i]);
        send_beat(ipv4dq_pkg::FUNC_END, 8'($urandom));
    endtask

    function automatic text_t to_text(input string s);
        text_t txt;
        txt = {};
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        return txt;
    endfunction

    // Hold the sender until every parsed address has come out
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random address text: mostly well formed, some damaged, some noise
    task automatic make_address(output text_t txt);
        int    kind;
        int    pick;
        int    n;
        int    v;
        int    i;
        string part;
        txt = {};
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            n = $urandom_range(0, 14);
            repeat (n)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    txt.push_back(8'(ipv4dq_pkg::ZERO_CHAR + $urandom_range(0, 9)));
                else if (pick < 7)
                    txt.push_back(ipv4dq_pkg::DOT_CHAR);
                else
                    txt.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            for (i = 0; i < 4; i++)
            begin
                if (i > 0)
                    txt.push_back(ipv4dq_pkg::DOT_CHAR);
                pick = $urandom_range(0, 99);
                if (kind >= 60 && pick < 6)
                    continue;
                if (kind >= 60 && pick < 14)
                    txt.push_back(ipv4dq_pkg::ZERO_CHAR);
                if (kind >= 60 && pick >= 14 && pick < 22)
                    v = $urandom_range(256, 99999);
                else if (pick >= 80 && pick < 88)
                    v = 0;
                else if (pick >= 88)
                    v = 255;
                else
                    v = $urandom_range(0, 255);
                part = $sformatf("%0d", v);
                for (n = 0; n < part.len(); n++)
                    txt.push_back(part[n]);
            end
            if (kind >= 60)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    txt.push_back(ipv4dq_pkg::DOT_CHAR);
                else if (pick < 18)
                begin
                    txt.push_back(ipv4dq_pkg::DOT_CHAR);
                    txt.push_back(8'(ipv4dq_pkg::ZERO_CHAR + $urandom_range(1, 9)));
                end
                else if (pick < 28)
                    txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                else if (pick < 36)
                    txt.delete($urandom_range(0, txt.size() - 1));
            end
        end
    endtask

    // Field extremes, each status and the priority corner cases
    task automatic test_directed();
        string      words[$];
        logic [7:0] odd_bytes[$];
        text_t      txt;
        words = {"", "0.0.0.0", "255.255.255.255", "192.168.0.1", "9.99.199.249",
                 "1.2.3.4.", "01.2.3.4", "0.0.0.00", "256.1.1.1", "1.2.3.99999",
                 "0123.1.1.1", "1.2.3", "1..2.3", ".1.2.3", "1.2.3.4.5",
                 "..........", "12a.1.1.1", "1.2.3.4 "};
        odd_bytes = {8'h00, 8'hFF, 8'h2F, 8'h3A, 8'h2D};
        foreach (words[i])
            send_text(to_text(words[i]));
        // bytes around the digit range and at both ends of the byte
        foreach (odd_bytes[i])
        begin
            txt = to_text("10.0.0.1");
            txt.push_back(odd_bytes[i]);
            send_text(txt);
        end
    endtask

    // Random addresses with a full drain halfway through
    task automatic test_random_addresses();
        text_t txt;
        for (int i = 0; i < 4; i++)
        begin
            if (i == 2)
                wait_drained();
            make_address(txt);
            send_text(txt);
        end
    endtask

    // Back-to-back beats with the result side always ready
    task automatic test_no_idle();
        text_t txt;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            make_address(txt);
            send_text(txt);
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Result side held off while end beats pile up behind it
    task automatic test_output_hold();
        text_t txt;
        src_gaps_on = 1'b0;
        rx_hold     = 300;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 4 == 3)
            begin
                make_address(txt);
                send_text(txt);
            end
            else
                send_beat(ipv4dq_pkg::FUNC_END, 8'($urandom));
        end
        src_gaps_on = 1'b1;
        wait_drained();
    endtask

    // Result side: random stalls per beat, plus a long hold on request
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            gap = sink_stalls_on ? $urandom_range(0, 9) : 0;
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid && rx_hold == 0);
        end
    end

    // Compare each result beat with the oldest parsed address
    always @(posedge clk)
    begin : check_result
        logic [ipv4dq_pkg::ADDR_W-1:0]   got_addr;
        logic [ipv4dq_pkg::STATUS_W-1:0] got_status;
        parse_result_t                   want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_addr   = m_axis_tdata[ipv4dq_pkg::ADDR_W-1:0];
            got_status = m_axis_tdata[ipv4dq_pkg::ADDR_W+ipv4dq_pkg::STATUS_W-1:
                                      ipv4dq_pkg::ADDR_W];
            if (parsed_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result beat: address %08h status %0d",
                             got_addr, got_status);
            end
            else
            begin
                want = parsed_q.pop_front();
                if (got_addr !== want.addr || got_status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"mismatch: expected address %08h status %0d (%s),",
                                  " got %08h status %0d"},
                                 want.addr, want.status, want.status.name(),
                                 got_addr, got_status);
                end
            end
        end
    end

    // Watchdog: no beat moving on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_addresses();
        test_no_idle();
        test_output_hold();
        test_random_addresses();
        s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && parsed_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
